>>> hw/rtl/isva_pkg.sv
// Package for the interval set value allocator.
// Holds sizes, operation codes and the request/response types of the modulo unit.
// No dependencies.
package isva_pkg;

    localparam int MAX_INTERVALS = 64;
    localparam int VALUE_BITS    = 16;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int ENTRY_W       = 2 * VALUE_BITS;

    localparam logic [2:0] FN_SEARCH = 3'd0;
    localparam logic [2:0] FN_TAKE   = 3'd1;
    localparam logic [2:0] FN_PICK   = 3'd2;
    localparam logic [2:0] FN_RESET  = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    localparam logic CFG_DEFAULT_LOW  = 1'b0;
    localparam logic CFG_DEFAULT_HIGH = 1'b1;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] rem;
    } mod_rsp_t;

endpackage

>>> hw/rtl/isva_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Holds the interval table; no package dependencies.
module isva_ram #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/isva_mod.sv
// Shared bit-serial restoring modulo unit, one quotient bit per cycle.
// Depends on isva_pkg for the request and response types.
module isva_mod
    import isva_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    localparam int STEP_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [VALUE_BITS-1:0] num_reg;
    logic [VALUE_BITS-1:0] div_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic                  done_reg;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   diff;

    assign shifted = {rem_reg, num_reg[VALUE_BITS-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(VALUE_BITS);
                num_reg  <= req.dividend;
                div_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                num_reg  <= {num_reg[VALUE_BITS-2:0], 1'b0};
                rem_reg  <= diff[VALUE_BITS] ? shifted[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> hw/rtl/isva_seq.sv
// Sequencer of the allocator: scans, edits and shifts the interval table in RAM,
// drives the shared modulo unit and holds the result register.
// Depends on isva_pkg, isva_ram and isva_mod.
module isva_seq
    import isva_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [2:0]                   req_func,
    input  logic signed [VALUE_BITS-1:0] req_query,
    input  logic [VALUE_BITS-1:0]        req_rint,
    input  logic [VALUE_BITS-1:0]        req_roff,
    input  logic signed [VALUE_BITS-1:0] dflt_low,
    input  logic signed [VALUE_BITS-1:0] dflt_high,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic                         res_found,
    output logic [VALUE_BITS-1:0]        res_picked,
    output logic [CNT_W-1:0]             res_count,
    output logic                         res_overflow
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_SCAN_RD, ST_SCAN_CHK, ST_MODI_WAIT, ST_PICK_RD,
        ST_PICK_CHK, ST_MODO_WAIT, ST_EXCL, ST_DN_RD, ST_DN_WR, ST_UP_RD, ST_UP_WR,
        ST_SPLIT_HI, ST_SPLIT_LO, ST_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [2:0]                   func_reg, func_next;
    logic signed [VALUE_BITS-1:0] q_reg, q_next;
    logic [VALUE_BITS-1:0]        rint_reg, rint_next;
    logic [VALUE_BITS-1:0]        roff_reg, roff_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             k_reg, k_next;
    logic signed [VALUE_BITS-1:0] lo_reg, lo_next;
    logic signed [VALUE_BITS-1:0] hi_reg, hi_next;
    logic signed [VALUE_BITS-1:0] v_reg, v_next;
    logic                         found_reg, found_next;
    logic                         ovf_reg, ovf_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_found_reg, m_found_next;
    logic [VALUE_BITS-1:0]        m_picked_reg, m_picked_next;
    logic [CNT_W-1:0]             m_cnt_reg, m_cnt_next;
    logic                         m_ovf_reg, m_ovf_next;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ENTRY_W-1:0]           ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [ENTRY_W-1:0]           ram_rdata;
    logic signed [VALUE_BITS-1:0] rd_lo;
    logic signed [VALUE_BITS-1:0] rd_hi;
    logic [VALUE_BITS-1:0]        span;
    mod_req_t                     mreq;
    mod_rsp_t                     mrsp;
    logic                         accept;

    isva_ram #(.DEPTH(MAX_INTERVALS), .DATA_W(ENTRY_W)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    isva_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign rd_lo     = $signed(ram_rdata[ENTRY_W-1:VALUE_BITS]);
    assign rd_hi     = $signed(ram_rdata[VALUE_BITS-1:0]);
    assign span      = VALUE_BITS'(hi_reg - lo_reg);
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        q_next        = q_reg;
        rint_next     = rint_reg;
        roff_next     = roff_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        v_next        = v_reg;
        found_next    = found_reg;
        ovf_next      = ovf_reg;
        m_valid_next  = m_valid_reg && !res_ready;
        m_found_next  = m_found_reg;
        m_picked_next = m_picked_reg;
        m_cnt_next    = m_cnt_reg;
        m_ovf_next    = m_ovf_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg[IDX_W-1:0];
        ram_wdata     = {lo_reg, hi_reg};
        ram_raddr     = idx_reg[IDX_W-1:0];
        mreq.start    = 1'b0;
        mreq.dividend = rint_reg;
        mreq.divisor  = VALUE_BITS'(cnt_reg);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next  = req_func;
                    q_next     = req_query;
                    v_next     = req_query;
                    rint_next  = req_rint;
                    roff_next  = req_roff;
                    idx_next   = '0;
                    found_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = ST_DONE;
                case (func_reg)
                    FN_SEARCH, FN_TAKE: begin
                        if (cnt_reg != '0) begin
                            state_next = ST_SCAN_RD;
                        end
                    end
                    FN_PICK: begin
                        if (cnt_reg != '0) begin
                            mreq.start = 1'b1;
                            state_next = ST_MODI_WAIT;
                        end
                    end
                    FN_RESET: begin
                        cnt_next = '0;
                        if (dflt_low < dflt_high) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = {dflt_low, dflt_high};
                            cnt_next  = CNT_W'(1);
                        end
                    end
                    FN_CLEAR: begin
                        cnt_next = '0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (rd_lo <= q_reg && q_reg < rd_hi) begin
                    lo_next = rd_lo;
                    hi_next = rd_hi;
                    if (func_reg == FN_SEARCH) begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_EXCL;
                    end
                end else if (idx_reg + 1'b1 == cnt_reg) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MODI_WAIT: begin
                if (mrsp.done) begin
                    idx_next   = CNT_W'(mrsp.rem);
                    state_next = ST_PICK_RD;
                end
            end
            ST_PICK_RD: begin
                state_next = ST_PICK_CHK;
            end
            ST_PICK_CHK: begin
                lo_next    = rd_lo;
                hi_next    = rd_hi;
                state_next = ST_MODO_WAIT;
                mreq.start    = 1'b1;
                mreq.dividend = roff_reg;
                mreq.divisor  = VALUE_BITS'(rd_hi - rd_lo);
            end
            ST_MODO_WAIT: begin
                mreq.dividend = roff_reg;
                mreq.divisor  = span;
                if (mrsp.done) begin
                    v_next     = lo_reg + $signed(mrsp.rem);
                    state_next = ST_EXCL;
                end
            end
            ST_EXCL: begin
                if (span == VALUE_BITS'(1)) begin
                    if (idx_reg + 1'b1 < cnt_reg) begin
                        k_next     = idx_reg;
                        state_next = ST_DN_RD;
                    end else begin
                        cnt_next   = cnt_reg - 1'b1;
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                end else if (v_reg == lo_reg) begin
                    ram_we     = 1'b1;
                    ram_wdata  = {v_reg + 1'b1, hi_reg};
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else if (v_reg == hi_reg - 1'b1) begin
                    ram_we     = 1'b1;
                    ram_wdata  = {lo_reg, v_reg};
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else if (cnt_reg >= CNT_W'(MAX_INTERVALS)) begin
                    ovf_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    k_next     = cnt_reg;
                    state_next = (cnt_reg > idx_reg + 1'b1) ? ST_UP_RD : ST_SPLIT_HI;
                end
            end
            ST_DN_RD: begin
                ram_raddr  = IDX_W'(k_reg + 1'b1);
                state_next = ST_DN_WR;
            end
            ST_DN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = k_reg[IDX_W-1:0];
                ram_wdata = ram_rdata;
                k_next    = k_reg + 1'b1;
                if (k_reg + 2'd2 < cnt_reg) begin
                    state_next = ST_DN_RD;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_UP_RD: begin
                ram_raddr  = IDX_W'(k_reg - 1'b1);
                state_next = ST_UP_WR;
            end
            ST_UP_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                k_next     = k_reg - 1'b1;
                state_next = (k_reg - 1'b1 > idx_reg + 1'b1) ? ST_UP_RD : ST_SPLIT_HI;
            end
            ST_SPLIT_HI: begin
                ram_we     = 1'b1;
                ram_waddr  = IDX_W'(idx_reg + 1'b1);
                ram_wdata  = {v_reg + 1'b1, hi_reg};
                state_next = ST_SPLIT_LO;
            end
            ST_SPLIT_LO: begin
                ram_we     = 1'b1;
                ram_wdata  = {lo_reg, v_reg};
                cnt_next   = cnt_reg + 1'b1;
                found_next = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || res_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = found_reg;
                    m_picked_next = v_reg;
                    m_cnt_next    = cnt_reg;
                    m_ovf_next    = ovf_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg     <= func_next;
        q_reg        <= q_next;
        rint_reg     <= rint_next;
        roff_reg     <= roff_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        v_reg        <= v_next;
        found_reg    <= found_next;
        ovf_reg      <= ovf_next;
        m_found_reg  <= m_found_next;
        m_picked_reg <= m_picked_next;
        m_cnt_reg    <= m_cnt_next;
        m_ovf_reg    <= m_ovf_next;
    end

    assign res_valid    = m_valid_reg;
    assign res_found    = m_found_reg;
    assign res_picked   = m_picked_reg;
    assign res_count    = m_cnt_reg;
    assign res_overflow = m_ovf_reg;

endmodule

>>> hw/rtl/interval_set_value_allocator.sv
// Top level of the interval set value allocator: configuration registers, port packing
// and checks. Depends on isva_pkg and isva_seq.
//
// Usage: requests enter on the s_ stream, func in s_tuser and the query and random
// words in s_tdata. Each request yields exactly one result on the m_ stream.
// The cfg channel writes default_low (index 0) and default_high (index 1); it is
// always ready and should be used only while no request is in flight.
// The time per request is set by the table walk in the simple dual-port interval RAM
// and the shared modulo unit: search and take read and check one interval at a time,
// a random pick runs two reductions before any entry moves, and a split or a removal
// moves one entry at a time with a read and a write; a reset or a clear goes straight
// from dispatch to its result.
// Only one request is worked on at a time; s_tready is high only when idle, from the
// cycle after the result is loaded.
// After reset the table is empty and the defaults are 0 and 1024; no clearing pass
// is needed. A stalled receiver holds the result in the output register; a new
// request can be accepted meanwhile, but its result waits until that one is taken.
module interval_set_value_allocator
    import isva_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // query_value[15:0], rand_interval[31:16], rand_offset[47:32]
    input  logic [2:0]  s_tuser,  // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // found[0], picked_value[16:1], intervals_in_use[23:17],
                                  // overflow[24], zero fill[31:25]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data
);

    logic signed [VALUE_BITS-1:0] dflt_low_reg;
    logic signed [VALUE_BITS-1:0] dflt_high_reg;
    logic                         found;
    logic [VALUE_BITS-1:0]        picked;
    logic [CNT_W-1:0]             count;
    logic                         overflow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_low_reg  <= '0;
            dflt_high_reg <= 16'sd1024;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_DEFAULT_LOW:  dflt_low_reg  <= $signed(cfg_data);
                CFG_DEFAULT_HIGH: dflt_high_reg <= $signed(cfg_data);
                default: begin
                end
            endcase
        end
    end

    isva_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req_func     (s_tuser),
        .req_query    ($signed(s_tdata[15:0])),
        .req_rint     (s_tdata[31:16]),
        .req_roff     (s_tdata[47:32]),
        .dflt_low     (dflt_low_reg),
        .dflt_high    (dflt_high_reg),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_found    (found),
        .res_picked   (picked),
        .res_count    (count),
        .res_overflow (overflow)
    );

    assign m_tdata = {7'd0, overflow, count, picked, found};

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:17] <= 7'(MAX_INTERVALS)))
        else $error("interval count out of range");

    a_ovf_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[24] && m_tdata[0]))
        else $error("overflow reported with found");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

endmodule
